FILE: design/apt_pkg.sv
package apt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_WIDTH  = 32;
	localparam int NUM_REGS    = 6;
	localparam int REG_WIDTH   = 2 * COEF_WIDTH;
	localparam int CFG_IDX_W   = $clog2(NUM_REGS);
	localparam int NUM_COEFS   = 2 * NUM_REGS;
	localparam int COEF_IDX_W  = $clog2(NUM_COEFS);

	// Product of a coordinate and a coefficient, and an exact sum of three
	// products plus the scaled translation.
	localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SHR_W  = SUM_W - FRAC_BITS;

	typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] coef_regs_t;

	// Identity matrix: m00, m11 and m22 hold 1.0, all else 0.0.
	localparam logic [REG_WIDTH-1:0] ONE_LOW = REG_WIDTH'(1) << FRAC_BITS;
	localparam coef_regs_t COEF_RESET = {
		{REG_WIDTH{1'b0}},
		ONE_LOW,
		{REG_WIDTH{1'b0}},
		ONE_LOW,
		{REG_WIDTH{1'b0}},
		ONE_LOW
	};

	typedef enum logic {
		OP_POINT     = 1'b0,
		OP_DIRECTION = 1'b1
	} op_t;

	// Stage advance enables handed to each output lane.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} apt_adv_t;

	// Coefficients feeding one output column j: m0j, m1j, m2j and m3j.
	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] m0;
		logic signed [COEF_WIDTH-1:0] m1;
		logic signed [COEF_WIDTH-1:0] m2;
		logic signed [COEF_WIDTH-1:0] m3;
	} apt_col_t;

	// Coefficient numbering m00 m01 m02 m10 ... m32; two to a register.
	function automatic logic signed [COEF_WIDTH-1:0] apt_coef(
		input coef_regs_t           regs,
		input logic [COEF_IDX_W-1:0] idx
	);
		logic [REG_WIDTH-1:0] r;
		r = regs[idx[COEF_IDX_W-1:1]];
		return idx[0] ? r[REG_WIDTH-1:COEF_WIDTH] : r[COEF_WIDTH-1:0];
	endfunction

endpackage

FILE: design/apt_if.sv
interface apt_in_if;
	import apt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic signed [COORD_WIDTH-1:0] in_x;
	logic signed [COORD_WIDTH-1:0] in_y;
	logic signed [COORD_WIDTH-1:0] in_z;

	modport source (output valid, operation, in_x, in_y, in_z, input ready);
	modport sink   (input valid, operation, in_x, in_y, in_z, output ready);
endinterface

interface apt_out_if;
	import apt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic                          saturated;

	modport source (output valid, out_x, out_y, out_z, saturated, input ready);
	modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: design/apt_lane.sv
module apt_lane (
	input  logic                                   clk,
	input  apt_pkg::apt_adv_t                      adv,
	input  logic                                   point_s1,
	input  logic signed [apt_pkg::COORD_WIDTH-1:0] x_s1,
	input  logic signed [apt_pkg::COORD_WIDTH-1:0] y_s1,
	input  logic signed [apt_pkg::COORD_WIDTH-1:0] z_s1,
	input  apt_pkg::apt_col_t                      col,
	output logic signed [apt_pkg::COORD_WIDTH-1:0] res_s4,
	output logic                                   sat_s4
);
	import apt_pkg::*;

	localparam int EXT_W = SUM_W - COEF_WIDTH - FRAC_BITS;

	logic signed [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic signed [SUM_W-1:0]  tr_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SHR_W-1:0]  shr;
	logic [SHR_W-COORD_WIDTH:0] top_bits;
	logic                     fits;

	// Stage 2: three products and the translation at product scale.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			px_s2 <= x_s1 * col.m0;
			py_s2 <= y_s1 * col.m1;
			pz_s2 <= z_s1 * col.m2;
			tr_s2 <= point_s1 ? {{EXT_W{col.m3[COEF_WIDTH-1]}}, col.m3, {FRAC_BITS{1'b0}}}
			                  : {SUM_W{1'b0}};
		end
	end

	// Stage 3: exact sum.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2) + tr_s2;
		end
	end

	// Stage 4: drop the fraction, clamp to the coordinate range.
	always_comb begin
		shr      = SHR_W'(sum_s3 >>> FRAC_BITS);
		top_bits = shr[SHR_W-1:COORD_WIDTH-1];
		fits     = (&top_bits) || !(|top_bits);
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			sat_s4 <= !fits;
			if (fits) begin
				res_s4 <= shr[COORD_WIDTH-1:0];
			end else if (sum_s3[SUM_W-1]) begin
				res_s4 <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				res_s4 <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
		end
	end
endmodule

FILE: design/affine_point_transform_top.sv
// Channel   | Direction | Beat contents
// ----------+-----------+------------------------------------------------
// pt_in     | sink      | operation, in_x, in_y, in_z (signed Q16.16)
// pt_out    | source    | out_x, out_y, out_z (signed Q16.16), saturated
// cfg_*     | sink      | cfg_we, cfg_idx, cfg_data: one coefficient pair
//
// Four register stages: input capture, multiply, sum, shift and clamp.
// Each input beat passes the stages in order; one beat enters per cycle
// while pt_in.ready is high; stage 2 has nine parallel 32x32 multipliers.
// Reset loads the identity matrix and empties every stage.
// A stall on pt_out holds only the stages behind a full stage; bubbles
// still close up, so pt_in keeps accepting while a result waits until
// all four stages hold a beat.
module affine_point_transform_top (
	input  logic                             clk,
	input  logic                             arst_n,
	apt_in_if.sink                           pt_in,
	apt_out_if.source                        pt_out,
	input  logic                             cfg_we,
	input  logic [apt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [apt_pkg::REG_WIDTH-1:0]    cfg_data
);
	import apt_pkg::*;

	coef_regs_t coef_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1;
	apt_adv_t adv;

	logic                          point_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;

	logic signed [COORD_WIDTH-1:0] res_s4 [3];
	logic [2:0]                    sat_s4;

	// Coefficient registers; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
			coef_q[cfg_idx] <= cfg_data;
		end
	end

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		adv.s4 = !v_s4 || pt_out.ready;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		en1    = !v_s1 || adv.s2;
	end

	assign pt_in.ready = en1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1)    v_s1 <= pt_in.valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: capture the input beat.
	always_ff @(posedge clk) begin
		if (en1) begin
			point_s1 <= (pt_in.operation == OP_POINT);
			x_s1     <= pt_in.in_x;
			y_s1     <= pt_in.in_y;
			z_s1     <= pt_in.in_z;
		end
	end

	// One lane per output column j.
	for (genvar j = 0; j < 3; j++) begin : g_lane
		apt_col_t col;

		always_comb begin
			col.m0 = apt_coef(coef_q, COEF_IDX_W'(j));
			col.m1 = apt_coef(coef_q, COEF_IDX_W'(3 + j));
			col.m2 = apt_coef(coef_q, COEF_IDX_W'(6 + j));
			col.m3 = apt_coef(coef_q, COEF_IDX_W'(9 + j));
		end

		apt_lane u_lane (
			.clk      (clk),
			.adv      (adv),
			.point_s1 (point_s1),
			.x_s1     (x_s1),
			.y_s1     (y_s1),
			.z_s1     (z_s1),
			.col      (col),
			.res_s4   (res_s4[j]),
			.sat_s4   (sat_s4[j])
		);
	end

	assign pt_out.valid     = v_s4;
	assign pt_out.out_x     = res_s4[0];
	assign pt_out.out_y     = res_s4[1];
	assign pt_out.out_z     = res_s4[2];
	assign pt_out.saturated = |sat_s4;
endmodule
